### rtl/chva_pkg.sv
package chva_pkg;

    localparam int COORD_W     = 15;
    localparam int CELL_W      = 17;
    localparam int OUT_COORD_W = 16;
    localparam int TRIG_W      = 32;
    localparam int Q_FRAC      = 30;
    localparam int RADIUS_W    = 8;
    localparam int WEIGHT_W    = 8;
    localparam int PEAK_W      = 24;
    localparam int MISS_W      = 16;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 8;

    localparam logic [CFG_INDEX_W-1:0] CFG_RADIUS_MIN  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_RADIUS_MAX  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_RADIUS_STEP = 2'd2;

    localparam logic ACT_CLEAR = 1'b0;
    localparam logic ACT_VOTE  = 1'b1;

    localparam logic [63:0] Q30_ONE     = 64'd1 << Q_FRAC;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0] SIN_DIV [8] = '{64'd6, 64'd20, 64'd42, 64'd72,
                                            64'd110, 64'd156, 64'd210, 64'd272};
    localparam logic [63:0] COS_DIV [8] = '{64'd2, 64'd12, 64'd30, 64'd56,
                                            64'd90, 64'd132, 64'd182, 64'd240};

    typedef struct packed {
        logic signed [TRIG_W-1:0] cos_v;
        logic signed [TRIG_W-1:0] sin_v;
    } trig_t;

    typedef struct packed {
        logic clear_start;
        logic vote_start;
        logic sweep;
        logic issue;
        logic load_result;
    } cmd_t;

    typedef struct packed {
        logic sweep_last;
        logic issue_last;
        logic range_empty;
        logic pipe_empty;
        logic out_free;
    } status_t;

    // Q2.30 cosine and sine of a phase given in Q32 turns
    function automatic trig_t unit_point(input logic [63:0] ph);
        logic [1:0]         quad;
        logic [63:0]        f;
        logic [63:0]        th;
        logic [63:0]        th2;
        logic [63:0]        ts;
        logic [63:0]        tc;
        logic signed [63:0] sv;
        logic signed [63:0] cv;
        trig_t              res;
        quad = ph[31:30];
        f    = {34'd0, ph[29:0]};
        th   = (f * HALF_PI_Q30) >> Q_FRAC;
        th2  = (th * th) >> Q_FRAC;
        ts   = th;
        tc   = Q30_ONE;
        sv   = signed'(th);
        cv   = signed'(Q30_ONE);
        for (int k = 0; k < 8; k++) begin
            ts = ((ts * th2) >> Q_FRAC) / SIN_DIV[k];
            tc = ((tc * th2) >> Q_FRAC) / COS_DIV[k];
            if ((k & 1) == 0) begin
                sv = sv - signed'(ts);
                cv = cv - signed'(tc);
            end else begin
                sv = sv + signed'(ts);
                cv = cv + signed'(tc);
            end
        end
        unique case (quad)
            2'd0: begin
                res.cos_v = cv[TRIG_W-1:0];
                res.sin_v = sv[TRIG_W-1:0];
            end
            2'd1: begin
                res.cos_v = TRIG_W'(-sv);
                res.sin_v = cv[TRIG_W-1:0];
            end
            2'd2: begin
                res.cos_v = TRIG_W'(-cv);
                res.sin_v = TRIG_W'(-sv);
            end
            default: begin
                res.cos_v = sv[TRIG_W-1:0];
                res.sin_v = TRIG_W'(-cv);
            end
        endcase
        return res;
    endfunction

endpackage

### rtl/chva_ram.sv
module chva_ram #(
    parameter int  WIDTH  = 24,
    parameter int  DEPTH  = 65536,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### rtl/chva_ctrl.sv
module chva_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    input  logic               s_action,
    output logic               s_ready,
    output chva_pkg::cmd_t     cmd,
    input  chva_pkg::status_t  status
);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_VOTE,
        ST_DRAIN,
        ST_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   report_reg;
    logic   report_next;

    always_comb begin
        state_next  = state_reg;
        report_next = report_reg;
        cmd         = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    if (s_action == chva_pkg::ACT_CLEAR) begin
                        cmd.clear_start = 1'b1;
                        report_next     = 1'b1;
                        state_next      = ST_CLEAR;
                    end else begin
                        cmd.vote_start = 1'b1;
                        state_next     = status.range_empty ? ST_DONE : ST_VOTE;
                    end
                end
            end
            ST_CLEAR: begin
                cmd.sweep = 1'b1;
                if (status.sweep_last) begin
                    state_next = report_reg ? ST_DONE : ST_IDLE;
                end
            end
            ST_VOTE: begin
                cmd.issue = 1'b1;
                if (status.issue_last) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (status.pipe_empty) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (status.out_free) begin
                    cmd.load_result = 1'b1;
                    report_next     = 1'b0;
                    state_next      = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // sweep the accumulator after reset before taking any request
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_CLEAR;
            report_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            report_reg <= report_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);

endmodule

### rtl/chva_datapath.sv
module chva_datapath #(
    parameter int GRID_WIDTH  = 256,
    parameter int GRID_HEIGHT = 256,
    parameter int ANGLE_COUNT = 180,
    parameter int VOTE_BITS   = 24
) (
    input  logic                                     aclk,
    input  logic                                     aresetn,
    input  chva_pkg::cmd_t                           cmd,
    output chva_pkg::status_t                        status,
    input  logic                                     cfg_valid,
    input  logic [chva_pkg::CFG_INDEX_W-1:0]         cfg_index,
    input  logic [chva_pkg::CFG_DATA_W-1:0]          cfg_data,
    input  logic signed [chva_pkg::COORD_W-1:0]      s_point_x,
    input  logic signed [chva_pkg::COORD_W-1:0]      s_point_y,
    input  logic [chva_pkg::WEIGHT_W-1:0]            s_intensity,
    input  logic                                     m_ready,
    output logic                                     m_valid,
    output logic [chva_pkg::PEAK_W-1:0]              m_peak_value,
    output logic signed [chva_pkg::OUT_COORD_W-1:0]  m_peak_x,
    output logic signed [chva_pkg::OUT_COORD_W-1:0]  m_peak_y,
    output logic signed [chva_pkg::OUT_COORD_W-1:0]  m_box_min_x,
    output logic signed [chva_pkg::OUT_COORD_W-1:0]  m_box_max_x,
    output logic signed [chva_pkg::OUT_COORD_W-1:0]  m_box_min_y,
    output logic signed [chva_pkg::OUT_COORD_W-1:0]  m_box_max_y,
    output logic [chva_pkg::MISS_W-1:0]              m_miss_count
);

    localparam int CELLS      = GRID_WIDTH * GRID_HEIGHT;
    localparam int ADDR_W     = $clog2(CELLS);
    localparam int ANGLE_W    = $clog2(ANGLE_COUNT);
    localparam int GW_W       = $clog2(GRID_WIDTH + 1) + 1;
    localparam int CELL_W     = chva_pkg::CELL_W;
    localparam int IDX_W      = CELL_W + GW_W + 1;
    localparam int RAD_W      = chva_pkg::RADIUS_W;
    localparam int PROD_W     = chva_pkg::TRIG_W + RAD_W + 1;
    localparam int SUM_W      = chva_pkg::COORD_W + chva_pkg::Q_FRAC + 2;
    localparam int ROUND_BIAS = (1 << chva_pkg::Q_FRAC) - 1;
    localparam int OW         = chva_pkg::OUT_COORD_W;

    localparam logic [RAD_W-1:0]       RADIUS_MIN_RESET  = 8'd11;
    localparam logic [RAD_W-1:0]       RADIUS_MAX_RESET  = 8'd12;
    localparam logic [RAD_W-1:0]       RADIUS_STEP_RESET = 8'd1;
    localparam logic signed [IDX_W-1:0] GRID_W_S         = IDX_W'(GRID_WIDTH);

    function automatic logic signed [CELL_W-1:0] cell_of(input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] adj;
        adj = v + (v[SUM_W-1] ? SUM_W'(ROUND_BIAS) : SUM_W'(0));
        adj = adj >>> chva_pkg::Q_FRAC;
        return adj[CELL_W-1:0];
    endfunction

    // angle table
    chva_pkg::trig_t trig_rom [ANGLE_COUNT];

    for (genvar g = 0; g < ANGLE_COUNT; g++) begin : g_trig
        localparam logic [63:0]     PHASE = (64'(g) << 32) / 64'(ANGLE_COUNT);
        localparam chva_pkg::trig_t TRIG  = chva_pkg::unit_point(PHASE);
        assign trig_rom[g] = TRIG;
    end

    // configuration
    logic [RAD_W-1:0] radius_min_reg;
    logic [RAD_W-1:0] radius_max_reg;
    logic [RAD_W-1:0] radius_step_reg;
    logic [RAD_W-1:0] step_eff;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radius_min_reg  <= RADIUS_MIN_RESET;
            radius_max_reg  <= RADIUS_MAX_RESET;
            radius_step_reg <= RADIUS_STEP_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                chva_pkg::CFG_RADIUS_MIN:  radius_min_reg  <= cfg_data;
                chva_pkg::CFG_RADIUS_MAX:  radius_max_reg  <= cfg_data;
                chva_pkg::CFG_RADIUS_STEP: radius_step_reg <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign step_eff = (radius_step_reg == '0) ? RAD_W'(1) : radius_step_reg;

    // request operands
    logic signed [chva_pkg::COORD_W-1:0] x_reg;
    logic signed [chva_pkg::COORD_W-1:0] y_reg;
    logic [chva_pkg::WEIGHT_W-1:0]       weight_reg;

    always_ff @(posedge aclk) begin
        if (cmd.vote_start) begin
            x_reg      <= s_point_x;
            y_reg      <= s_point_y;
            weight_reg <= 8'd255 - s_intensity;
        end
    end

    // angle and radius counters
    logic [ANGLE_W-1:0] angle_reg;
    logic [RAD_W:0]     radius_reg;
    logic [RAD_W:0]     radius_next;
    logic               angle_last;

    assign radius_next = radius_reg + {1'b0, step_eff};
    assign angle_last  = (angle_reg == ANGLE_W'(ANGLE_COUNT - 1));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            angle_reg  <= '0;
            radius_reg <= '0;
        end else if (cmd.vote_start) begin
            angle_reg  <= '0;
            radius_reg <= {1'b0, radius_min_reg};
        end else if (cmd.issue) begin
            if (angle_last) begin
                angle_reg  <= '0;
                radius_reg <= radius_next;
            end else begin
                angle_reg <= angle_reg + ANGLE_W'(1);
            end
        end
    end

    // stage A: table lookup
    logic             a_vld_reg;
    chva_pkg::trig_t  a_trig_reg;
    logic [RAD_W-1:0] a_radius_reg;

    always_ff @(posedge aclk) begin
        a_trig_reg   <= trig_rom[angle_reg];
        a_radius_reg <= radius_reg[RAD_W-1:0];
    end

    // stage B: radius times cosine and sine
    logic                             b_vld_reg;
    logic signed [RAD_W:0]            a_rad_s;
    logic signed [chva_pkg::TRIG_W-1:0] a_cos;
    logic signed [chva_pkg::TRIG_W-1:0] a_sin;
    logic signed [PROD_W-1:0]         pcos;
    logic signed [PROD_W-1:0]         psin;
    logic signed [PROD_W-1:0]         b_pcos_reg;
    logic signed [PROD_W-1:0]         b_psin_reg;

    assign a_rad_s = {1'b0, a_radius_reg};
    assign a_cos   = a_trig_reg.cos_v;
    assign a_sin   = a_trig_reg.sin_v;
    assign pcos    = a_rad_s * a_cos;
    assign psin    = a_rad_s * a_sin;

    always_ff @(posedge aclk) begin
        b_pcos_reg <= pcos;
        b_psin_reg <= psin;
    end

    // stage C: add the point and truncate toward zero
    logic                     c_vld_reg;
    logic signed [SUM_W-1:0]  x_q;
    logic signed [SUM_W-1:0]  y_q;
    logic signed [SUM_W-1:0]  vx;
    logic signed [SUM_W-1:0]  vy;
    logic signed [CELL_W-1:0] c_cx_reg;
    logic signed [CELL_W-1:0] c_cy_reg;

    assign x_q = SUM_W'(x_reg) <<< chva_pkg::Q_FRAC;
    assign y_q = SUM_W'(y_reg) <<< chva_pkg::Q_FRAC;
    assign vx  = x_q + SUM_W'(b_pcos_reg);
    assign vy  = y_q + SUM_W'(b_psin_reg);

    always_ff @(posedge aclk) begin
        c_cx_reg <= cell_of(vx);
        c_cy_reg <= cell_of(vy);
    end

    // stage D: linear index, range check, memory read
    logic                     d_vld_reg;
    logic                     d_hit_reg;
    logic [ADDR_W-1:0]        d_addr_reg;
    logic signed [CELL_W-1:0] d_cx_reg;
    logic signed [CELL_W-1:0] d_cy_reg;
    logic signed [IDX_W-1:0]  lin_idx;
    logic                     lin_hit;

    assign lin_idx = IDX_W'(c_cy_reg) * GRID_W_S + IDX_W'(c_cx_reg);
    assign lin_hit = !lin_idx[IDX_W-1] && (lin_idx < IDX_W'(CELLS));

    always_ff @(posedge aclk) begin
        d_hit_reg  <= lin_hit;
        d_addr_reg <= lin_idx[ADDR_W-1:0];
        d_cx_reg   <= c_cx_reg;
        d_cy_reg   <= c_cy_reg;
    end

    // bounding box
    logic signed [CELL_W-1:0] low_x_reg;
    logic signed [CELL_W-1:0] high_x_reg;
    logic signed [CELL_W-1:0] low_y_reg;
    logic signed [CELL_W-1:0] high_y_reg;
    logic                     cx_pos;
    logic                     cy_pos;

    assign cx_pos = !d_cx_reg[CELL_W-1] && (d_cx_reg != '0);
    assign cy_pos = !d_cy_reg[CELL_W-1] && (d_cy_reg != '0);

    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.clear_start) begin
            low_x_reg  <= CELL_W'(GRID_WIDTH);
            high_x_reg <= '0;
            low_y_reg  <= CELL_W'(GRID_HEIGHT);
            high_y_reg <= '0;
        end else if (d_vld_reg) begin
            if (d_cx_reg > high_x_reg) begin
                high_x_reg <= d_cx_reg;
            end
            if (cx_pos && (d_cx_reg < low_x_reg)) begin
                low_x_reg <= d_cx_reg;
            end
            if (d_cy_reg > high_y_reg) begin
                high_y_reg <= d_cy_reg;
            end
            if (cy_pos && (d_cy_reg < low_y_reg)) begin
                low_y_reg <= d_cy_reg;
            end
        end
    end

    // stage E: add the weight, write back, track the peak
    logic                     e_vld_reg;
    logic                     e_hit_reg;
    logic [ADDR_W-1:0]        e_addr_reg;
    logic signed [CELL_W-1:0] e_cx_reg;
    logic signed [CELL_W-1:0] e_cy_reg;
    logic [VOTE_BITS-1:0]     rd_data;
    logic [VOTE_BITS-1:0]     base;
    logic [VOTE_BITS:0]       sum_wide;
    logic [VOTE_BITS-1:0]     sum_sat;
    logic                     e_write;
    logic                     fwd_vld_reg;
    logic [ADDR_W-1:0]        fwd_addr_reg;
    logic [VOTE_BITS-1:0]     fwd_data_reg;

    always_ff @(posedge aclk) begin
        e_hit_reg  <= d_hit_reg;
        e_addr_reg <= d_addr_reg;
        e_cx_reg   <= d_cx_reg;
        e_cy_reg   <= d_cy_reg;
    end

    // forward the write that landed in the cycle of this read
    assign base     = (fwd_vld_reg && (fwd_addr_reg == e_addr_reg)) ? fwd_data_reg : rd_data;
    assign sum_wide = {1'b0, base} + (VOTE_BITS + 1)'(weight_reg);
    assign sum_sat  = sum_wide[VOTE_BITS] ? '1 : sum_wide[VOTE_BITS-1:0];
    assign e_write  = e_vld_reg && e_hit_reg;

    always_ff @(posedge aclk) begin
        fwd_addr_reg <= e_addr_reg;
        fwd_data_reg <= sum_sat;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_vld_reg   <= 1'b0;
            b_vld_reg   <= 1'b0;
            c_vld_reg   <= 1'b0;
            d_vld_reg   <= 1'b0;
            e_vld_reg   <= 1'b0;
            fwd_vld_reg <= 1'b0;
        end else begin
            a_vld_reg   <= cmd.issue;
            b_vld_reg   <= a_vld_reg;
            c_vld_reg   <= b_vld_reg;
            d_vld_reg   <= c_vld_reg;
            e_vld_reg   <= d_vld_reg;
            fwd_vld_reg <= e_write;
        end
    end

    logic [VOTE_BITS-1:0]     best_reg;
    logic signed [CELL_W-1:0] best_x_reg;
    logic signed [CELL_W-1:0] best_y_reg;
    logic [chva_pkg::MISS_W-1:0] miss_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.clear_start) begin
            best_reg   <= '0;
            best_x_reg <= '0;
            best_y_reg <= '0;
        end else if (e_write && (sum_sat > best_reg)) begin
            best_reg   <= sum_sat;
            best_x_reg <= e_cx_reg;
            best_y_reg <= e_cy_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.clear_start || cmd.vote_start) begin
            miss_reg <= '0;
        end else if (e_vld_reg && !e_hit_reg && (miss_reg != '1)) begin
            miss_reg <= miss_reg + chva_pkg::MISS_W'(1);
        end
    end

    // clearing sweep
    logic [ADDR_W-1:0] sweep_addr_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.clear_start) begin
            sweep_addr_reg <= '0;
        end else if (cmd.sweep) begin
            sweep_addr_reg <= sweep_addr_reg + ADDR_W'(1);
        end
    end

    logic                 ram_we;
    logic [ADDR_W-1:0]    ram_waddr;
    logic [VOTE_BITS-1:0] ram_wdata;

    assign ram_we    = cmd.sweep || e_write;
    assign ram_waddr = cmd.sweep ? sweep_addr_reg : e_addr_reg;
    assign ram_wdata = cmd.sweep ? '0 : sum_sat;

    chva_ram #(
        .WIDTH (VOTE_BITS),
        .DEPTH (CELLS)
    ) u_vote_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (d_addr_reg),
        .rdata (rd_data)
    );

    // result register
    logic                                    m_valid_reg;
    logic [chva_pkg::PEAK_W-1:0]             m_peak_value_reg;
    logic signed [OW-1:0]                    m_peak_x_reg;
    logic signed [OW-1:0]                    m_peak_y_reg;
    logic signed [OW-1:0]                    m_box_min_x_reg;
    logic signed [OW-1:0]                    m_box_max_x_reg;
    logic signed [OW-1:0]                    m_box_min_y_reg;
    logic signed [OW-1:0]                    m_box_max_y_reg;
    logic [chva_pkg::MISS_W-1:0]             m_miss_count_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.load_result) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_result) begin
            m_peak_value_reg <= chva_pkg::PEAK_W'(best_reg);
            m_peak_x_reg     <= best_x_reg[OW-1:0];
            m_peak_y_reg     <= best_y_reg[OW-1:0];
            m_box_min_x_reg  <= low_x_reg[OW-1:0];
            m_box_max_x_reg  <= high_x_reg[OW-1:0];
            m_box_min_y_reg  <= low_y_reg[OW-1:0];
            m_box_max_y_reg  <= high_y_reg[OW-1:0];
            m_miss_count_reg <= miss_reg;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_peak_value = m_peak_value_reg;
    assign m_peak_x     = m_peak_x_reg;
    assign m_peak_y     = m_peak_y_reg;
    assign m_box_min_x  = m_box_min_x_reg;
    assign m_box_max_x  = m_box_max_x_reg;
    assign m_box_min_y  = m_box_min_y_reg;
    assign m_box_max_y  = m_box_max_y_reg;
    assign m_miss_count = m_miss_count_reg;

    assign status.sweep_last  = (sweep_addr_reg == ADDR_W'(CELLS - 1));
    assign status.issue_last  = angle_last && (radius_next > {1'b0, radius_max_reg});
    assign status.range_empty = (radius_min_reg > radius_max_reg);
    assign status.pipe_empty  = !(a_vld_reg || b_vld_reg || c_vld_reg || d_vld_reg || e_vld_reg);
    assign status.out_free    = !m_valid_reg || m_ready;

endmodule

### rtl/circle_hough_vote_accumulator_core.sv
// Circular Hough vote accumulator. A vote request (action 1) casts one vote
// per radius and per table angle into a GRID_WIDTH x GRID_HEIGHT accumulator
// memory, nR * ANGLE_COUNT votes in all, nR being the number of radii from
// radius_min to radius_max in radius_step, at one read-modify-write of the
// accumulator memory per cycle. An empty radius range casts no vote. A clear
// request (action 0), and reset, sweep the memory one cell per cycle over
// GRID_WIDTH * GRID_HEIGHT cells (65536 at the defaults), during which no
// request is taken; configuration writes are taken at any time but must only
// be issued while idle. One request is in work at a time; its result sits in
// an output register, so the next request can start while the previous
// result waits for m_ready.
module circle_hough_vote_accumulator_core #(
    parameter int GRID_WIDTH  = 256,
    parameter int GRID_HEIGHT = 256,
    parameter int ANGLE_COUNT = 180,
    parameter int VOTE_BITS   = 24
) (
    input  logic                                     aclk,
    input  logic                                     aresetn,
    input  logic                                     s_valid,
    output logic                                     s_ready,
    input  logic                                     s_action,
    input  logic signed [chva_pkg::COORD_W-1:0]      s_point_x,
    input  logic signed [chva_pkg::COORD_W-1:0]      s_point_y,
    input  logic [chva_pkg::WEIGHT_W-1:0]            s_intensity,
    output logic                                     m_valid,
    input  logic                                     m_ready,
    output logic [chva_pkg::PEAK_W-1:0]              m_peak_value,
    output logic signed [chva_pkg::OUT_COORD_W-1:0]  m_peak_x,
    output logic signed [chva_pkg::OUT_COORD_W-1:0]  m_peak_y,
    output logic signed [chva_pkg::OUT_COORD_W-1:0]  m_box_min_x,
    output logic signed [chva_pkg::OUT_COORD_W-1:0]  m_box_max_x,
    output logic signed [chva_pkg::OUT_COORD_W-1:0]  m_box_min_y,
    output logic signed [chva_pkg::OUT_COORD_W-1:0]  m_box_max_y,
    output logic [chva_pkg::MISS_W-1:0]              m_miss_count,
    input  logic                                     cfg_valid,
    output logic                                     cfg_ready,
    input  logic [chva_pkg::CFG_INDEX_W-1:0]         cfg_index,
    input  logic [chva_pkg::CFG_DATA_W-1:0]          cfg_data
);

    chva_pkg::cmd_t    cmd;
    chva_pkg::status_t status;

    assign cfg_ready = 1'b1;

    chva_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_action (s_action),
        .s_ready  (s_ready),
        .cmd      (cmd),
        .status   (status)
    );

    chva_datapath #(
        .GRID_WIDTH  (GRID_WIDTH),
        .GRID_HEIGHT (GRID_HEIGHT),
        .ANGLE_COUNT (ANGLE_COUNT),
        .VOTE_BITS   (VOTE_BITS)
    ) u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .status       (status),
        .cfg_valid    (cfg_valid),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .s_point_x    (s_point_x),
        .s_point_y    (s_point_y),
        .s_intensity  (s_intensity),
        .m_ready      (m_ready),
        .m_valid      (m_valid),
        .m_peak_value (m_peak_value),
        .m_peak_x     (m_peak_x),
        .m_peak_y     (m_peak_y),
        .m_box_min_x  (m_box_min_x),
        .m_box_max_x  (m_box_max_x),
        .m_box_min_y  (m_box_min_y),
        .m_box_max_y  (m_box_max_y),
        .m_miss_count (m_miss_count)
    );

endmodule

### rtl/chva_checker.sv
module chva_checker (
    input logic                                     aclk,
    input logic                                     aresetn,
    input logic                                     s_valid,
    input logic                                     s_ready,
    input logic                                     m_valid,
    input logic                                     m_ready,
    input logic [chva_pkg::PEAK_W-1:0]              m_peak_value,
    input logic signed [chva_pkg::OUT_COORD_W-1:0]  m_peak_x,
    input logic signed [chva_pkg::OUT_COORD_W-1:0]  m_peak_y,
    input logic signed [chva_pkg::OUT_COORD_W-1:0]  m_box_min_x,
    input logic signed [chva_pkg::OUT_COORD_W-1:0]  m_box_max_x,
    input logic signed [chva_pkg::OUT_COORD_W-1:0]  m_box_min_y,
    input logic signed [chva_pkg::OUT_COORD_W-1:0]  m_box_max_y,
    input logic [chva_pkg::MISS_W-1:0]              m_miss_count
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_peak_value) && $stable(m_peak_x)
            && $stable(m_peak_y) && $stable(m_box_min_x) && $stable(m_box_max_x)
            && $stable(m_box_min_y) && $stable(m_box_max_y) && $stable(m_miss_count))
        else $error("result changed while stalled");

    a_one_request: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("request taken while another is in work");

    a_init_sweep: assert property (@(posedge aclk) disable iff (!aresetn)
        !$past(aresetn) |-> !s_ready)
        else $error("request taken before the accumulator was cleared");

    a_box_min_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_box_min_x > 16'sd0) && (m_box_min_y > 16'sd0))
        else $error("box minimum not positive");

endmodule

bind circle_hough_vote_accumulator_core chva_checker u_chva_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_valid      (s_valid),
    .s_ready      (s_ready),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_peak_value (m_peak_value),
    .m_peak_x     (m_peak_x),
    .m_peak_y     (m_peak_y),
    .m_box_min_x  (m_box_min_x),
    .m_box_max_x  (m_box_max_x),
    .m_box_min_y  (m_box_min_y),
    .m_box_max_y  (m_box_max_y),
    .m_miss_count (m_miss_count)
);

### dv/chva_vote_checker.sv
`timescale 1ns / 100ps

module chva_vote_checker
    import chva_pkg::*;
#(
    parameter int GRID_WIDTH  = 256,
    parameter int GRID_HEIGHT = 256,
    parameter int ANGLE_COUNT = 180,
    parameter int VOTE_BITS   = 24
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    input  logic                          s_ready,
    input  logic                          s_action,
    input  logic signed [COORD_W-1:0]     s_point_x,
    input  logic signed [COORD_W-1:0]     s_point_y,
    input  logic [WEIGHT_W-1:0]           s_intensity,
    input  logic                          m_valid,
    input  logic                          m_ready,
    input  logic [PEAK_W-1:0]             m_peak_value,
    input  logic signed [OUT_COORD_W-1:0] m_peak_x,
    input  logic signed [OUT_COORD_W-1:0] m_peak_y,
    input  logic signed [OUT_COORD_W-1:0] m_box_min_x,
    input  logic signed [OUT_COORD_W-1:0] m_box_max_x,
    input  logic signed [OUT_COORD_W-1:0] m_box_min_y,
    input  logic signed [OUT_COORD_W-1:0] m_box_max_y,
    input  logic [MISS_W-1:0]             m_miss_count,
    input  logic                          cfg_valid,
    input  logic                          cfg_ready,
    input  logic [CFG_INDEX_W-1:0]        cfg_index,
    input  logic [CFG_DATA_W-1:0]         cfg_data,
    output int                            mismatch_count,
    output int                            tallies_due
);

    localparam int          CELL_COUNT  = GRID_WIDTH * GRID_HEIGHT;
    localparam longint      VOTE_LIMIT  = (longint'(1) << VOTE_BITS) - 1;
    localparam longint      ONE_Q30     = longint'(1) << 30;
    localparam longint unsigned QUARTER_TURN = 64'd1686629713;
    localparam int          MISS_LIMIT  = 65535;

    typedef longint unsigned u64_t;

    typedef struct {
        logic [PEAK_W-1:0]             peak_value;
        logic signed [OUT_COORD_W-1:0] peak_x;
        logic signed [OUT_COORD_W-1:0] peak_y;
        logic signed [OUT_COORD_W-1:0] box_min_x;
        logic signed [OUT_COORD_W-1:0] box_max_x;
        logic signed [OUT_COORD_W-1:0] box_min_y;
        logic signed [OUT_COORD_W-1:0] box_max_y;
        logic [MISS_W-1:0]             miss_count;
    } tally_t;

    longint              cos_tab [ANGLE_COUNT];
    longint              sin_tab [ANGLE_COUNT];
    bit [VOTE_BITS-1:0]  votes [CELL_COUNT];
    longint              best_count;
    int                  best_x;
    int                  best_y;
    int                  low_x;
    int                  high_x;
    int                  low_y;
    int                  high_y;
    int                  rad_min;
    int                  rad_max;
    int                  rad_step;
    tally_t              tally_q [$];

    initial begin
        longint unsigned ph;
        longint unsigned f;
        longint unsigned th;
        longint unsigned th2;
        longint unsigned ts;
        longint unsigned tc;
        longint          sv;
        longint          cv;
        for (int p = 0; p < ANGLE_COUNT; p++) begin
            ph  = (u64_t'(p) << 32) / u64_t'(ANGLE_COUNT);
            f   = ph & (u64_t'(ONE_Q30) - 1);
            th  = (f * QUARTER_TURN) >> 30;
            th2 = (th * th) >> 30;
            ts  = th;
            tc  = u64_t'(ONE_Q30);
            sv  = longint'(th);
            cv  = ONE_Q30;
            for (int k = 1; k <= 8; k++) begin
                ts = ((ts * th2) >> 30) / u64_t'((2 * k) * (2 * k + 1));
                tc = ((tc * th2) >> 30) / u64_t'((2 * k - 1) * (2 * k));
                if (k % 2 == 1) begin
                    sv = sv - longint'(ts);
                    cv = cv - longint'(tc);
                end else begin
                    sv = sv + longint'(ts);
                    cv = cv + longint'(tc);
                end
            end
            case (ph[31:30])
                2'd0: begin
                    cos_tab[p] = cv;
                    sin_tab[p] = sv;
                end
                2'd1: begin
                    cos_tab[p] = -sv;
                    sin_tab[p] = cv;
                end
                2'd2: begin
                    cos_tab[p] = -cv;
                    sin_tab[p] = -sv;
                end
                default: begin
                    cos_tab[p] = sv;
                    sin_tab[p] = -cv;
                end
            endcase
        end
    end

    function automatic int cell_at(input int base, input int r, input longint trig);
        longint v;
        v = longint'(base) * ONE_Q30 + longint'(r) * trig;
        if (v >= 0)
            return int'(v >>> 30);
        return -int'((-v) >>> 30);
    endfunction

    task automatic wipe_accumulator();
        votes      = '{default: '0};
        best_count = 0;
        best_x     = 0;
        best_y     = 0;
        low_x      = GRID_WIDTH;
        high_x     = 0;
        low_y      = GRID_HEIGHT;
        high_y     = 0;
    endtask

    task automatic cast_votes(input logic act, input int px, input int py,
                              input int inten, output tally_t t);
        int     misses;
        int     weight;
        int     stride;
        int     cx;
        int     cy;
        longint lin;
        longint sum;
        misses = 0;
        if (act == ACT_CLEAR) begin
            wipe_accumulator();
        end else begin
            weight = 255 - inten;
            stride = (rad_step == 0) ? 1 : rad_step;
            for (int r = rad_min; r <= rad_max; r += stride) begin
                for (int p = 0; p < ANGLE_COUNT; p++) begin
                    cx = cell_at(px, r, cos_tab[p]);
                    cy = cell_at(py, r, sin_tab[p]);
                    if (cx > high_x) high_x = cx;
                    if (cx < low_x && cx > 0) low_x = cx;
                    if (cy > high_y) high_y = cy;
                    if (cy < low_y && cy > 0) low_y = cy;
                    lin = longint'(cy) * GRID_WIDTH + cx;
                    if (lin >= 0 && lin < CELL_COUNT) begin
                        sum = longint'(votes[lin]) + weight;
                        if (sum > VOTE_LIMIT) sum = VOTE_LIMIT;
                        votes[lin] = sum[VOTE_BITS-1:0];
                        if (sum > best_count) begin
                            best_count = sum;
                            best_x     = cx;
                            best_y     = cy;
                        end
                    end else if (misses < MISS_LIMIT) begin
                        misses++;
                    end
                end
            end
        end
        t.peak_value = best_count[PEAK_W-1:0];
        t.peak_x     = best_x[OUT_COORD_W-1:0];
        t.peak_y     = best_y[OUT_COORD_W-1:0];
        t.box_min_x  = low_x[OUT_COORD_W-1:0];
        t.box_max_x  = high_x[OUT_COORD_W-1:0];
        t.box_min_y  = low_y[OUT_COORD_W-1:0];
        t.box_max_y  = high_y[OUT_COORD_W-1:0];
        t.miss_count = misses[MISS_W-1:0];
    endtask

    task automatic check_field(input string name, input logic signed [31:0] want,
                               input logic signed [31:0] got);
        if (got !== want) begin
            $error("%s expected %0d got %0d", name, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge aclk) begin : watch
        tally_t want;
        if (!aresetn) begin
            wipe_accumulator();
            rad_min  = 11;
            rad_max  = 12;
            rad_step = 1;
            tally_q.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_RADIUS_MIN:  rad_min  = cfg_data;
                    CFG_RADIUS_MAX:  rad_max  = cfg_data;
                    CFG_RADIUS_STEP: rad_step = cfg_data;
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                cast_votes(s_action, s_point_x, s_point_y, s_intensity, want);
                tally_q.insert(tally_q.size(), want);
            end
            if (m_valid && m_ready) begin
                if (tally_q.size() == 0) begin
                    $error("result with no request outstanding");
                    mismatch_count++;
                end else begin
                    want = tally_q.pop_front();
                    check_field("peak_value", want.peak_value, m_peak_value);
                    check_field("peak_x", want.peak_x, m_peak_x);
                    check_field("peak_y", want.peak_y, m_peak_y);
                    check_field("box_min_x", want.box_min_x, m_box_min_x);
                    check_field("box_max_x", want.box_max_x, m_box_max_x);
                    check_field("box_min_y", want.box_min_y, m_box_min_y);
                    check_field("box_max_y", want.box_max_y, m_box_max_y);
                    check_field("miss_count", want.miss_count, m_miss_count);
                end
            end
        end
        tallies_due = tally_q.size();
    end

endmodule

### dv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import chva_pkg::*;

    localparam int GRID_WIDTH       = 256;
    localparam int GRID_HEIGHT      = 256;
    localparam int ANGLE_COUNT      = 180;
    localparam int VOTE_BITS        = 24;
    localparam int CYCLE_LIMIT      = 4_000_000;
    localparam int RANDOM_PER_PHASE = 176;
    localparam int DRAIN_CYCLES     = 400;

    logic                          aclk;
    logic                          aresetn;
    logic                          s_valid;
    logic                          s_ready;
    logic                          s_action;
    logic signed [COORD_W-1:0]     s_point_x;
    logic signed [COORD_W-1:0]     s_point_y;
    logic [WEIGHT_W-1:0]           s_intensity;
    logic                          m_valid;
    logic                          m_ready;
    logic [PEAK_W-1:0]             m_peak_value;
    logic signed [OUT_COORD_W-1:0] m_peak_x;
    logic signed [OUT_COORD_W-1:0] m_peak_y;
    logic signed [OUT_COORD_W-1:0] m_box_min_x;
    logic signed [OUT_COORD_W-1:0] m_box_max_x;
    logic signed [OUT_COORD_W-1:0] m_box_min_y;
    logic signed [OUT_COORD_W-1:0] m_box_max_y;
    logic [MISS_W-1:0]             m_miss_count;
    logic                          cfg_valid;
    logic                          cfg_ready;
    logic [CFG_INDEX_W-1:0]        cfg_index;
    logic [CFG_DATA_W-1:0]         cfg_data;
    int                            mismatch_count;
    int                            tallies_due;
    int                            send_idle;
    int                            recv_idle;
    int                            cycle_count;

    circle_hough_vote_accumulator_core #(
        .GRID_WIDTH (GRID_WIDTH),
        .GRID_HEIGHT(GRID_HEIGHT),
        .ANGLE_COUNT(ANGLE_COUNT),
        .VOTE_BITS  (VOTE_BITS)
    ) dut (.*);

    chva_vote_checker #(
        .GRID_WIDTH (GRID_WIDTH),
        .GRID_HEIGHT(GRID_HEIGHT),
        .ANGLE_COUNT(ANGLE_COUNT),
        .VOTE_BITS  (VOTE_BITS)
    ) u_checker (.*);

    always begin
        aclk = 1'b0;
        #10;
        aclk = 1'b1;
        #10;
    end

    always @(negedge aclk) begin
        m_ready = ($urandom_range(1, 100) > recv_idle);
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic send_request(input logic act, input int px, input int py, input int inten);
        while ($urandom_range(1, 100) <= send_idle) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid     = 1'b1;
        s_action    = act;
        s_point_x   = px[COORD_W-1:0];
        s_point_y   = py[COORD_W-1:0];
        s_intensity = inten[WEIGHT_W-1:0];
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    task automatic vote(input int px, input int py, input int inten);
        send_request(ACT_VOTE, px, py, inten);
    endtask

    task automatic wipe();
        send_request(ACT_CLEAR, $urandom_range(0, 32767) - 16384,
                     $urandom_range(0, 32767) - 16384, $urandom_range(0, 255));
    endtask

    // hold off until every result is back
    task automatic settle();
        s_valid = 1'b0;
        while (tallies_due != 0) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input int data);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = data[CFG_DATA_W-1:0];
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    task automatic set_radii(input int lo, input int hi, input int st);
        settle();
        write_reg(CFG_RADIUS_MIN, lo);
        write_reg(CFG_RADIUS_MAX, hi);
        write_reg(CFG_RADIUS_STEP, st);
    endtask

    // keep the radius count small so each vote stays cheap
    task automatic pick_radii();
        int lo;
        int hi;
        int st;
        int eff;
        int count;
        lo    = $urandom_range(0, 255);
        st    = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : $urandom_range(1, 6);
        eff   = (st == 0) ? 1 : st;
        count = $urandom_range(0, 3);
        if (count == 0 && lo > 0)
            hi = $urandom_range(0, lo - 1);
        else if (count == 0)
            hi = 0;
        else
            hi = lo + (count - 1) * eff + $urandom_range(0, eff - 1);
        if (hi > 255) hi = 255;
        set_radii(lo, hi, st);
    endtask

    initial begin
        int kind;
        int cx0;
        int cy0;
        aresetn     = 1'b0;
        s_valid     = 1'b0;
        s_action    = ACT_VOTE;
        s_point_x   = '0;
        s_point_y   = '0;
        s_intensity = '0;
        cfg_valid   = 1'b0;
        cfg_index   = CFG_RADIUS_MIN;
        cfg_data    = '0;
        send_idle   = 34;
        recv_idle   = 50;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        vote(128, 128, 0);
        vote(128, 128, 255);
        vote(128, 128, 0);
        vote(0, 0, 17);
        vote(-16384, -16384, 200);
        vote(16383, 16383, 1);
        vote(-16384, 16383, 90);
        vote(16383, -16384, 254);
        vote(3, 100, 50);
        vote(255, 255, 0);
        vote(250, 5, 128);
        vote(-1, -1, 7);
        wipe();
        vote(40, 60, 0);
        set_radii(20, 10, 1);
        vote(100, 100, 0);
        set_radii(5, 7, 0);
        vote(60, 60, 10);
        set_radii(0, 0, 1);
        vote(7, 9, 0);
        vote(7, 9, 0);
        set_radii(255, 255, 255);
        vote(128, 128, 3);
        set_radii(1, 255, 255);
        vote(200, 30, 0);
        set_radii(1, 255, 1);
        vote(128, 128, 0);

        for (int ph = 0; ph < 3; ph++) begin
            send_idle = (ph == 0) ? 34 : (ph == 1) ? 50 : 0;
            recv_idle = (ph == 0) ? 50 : (ph == 1) ? 34 : 0;
            pick_radii();
            wipe();
            cx0 = $urandom_range(20, 235);
            cy0 = $urandom_range(20, 235);
            for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
                if (i % 60 == 59) begin
                    pick_radii();
                    cx0 = $urandom_range(20, 235);
                    cy0 = $urandom_range(20, 235);
                end
                kind = $urandom_range(0, 99);
                if (kind < 65)
                    vote(cx0 + $urandom_range(0, 8) - 4, cy0 + $urandom_range(0, 8) - 4,
                         $urandom_range(0, 255));
                else if (kind < 88)
                    vote($urandom_range(0, 855) - 300, $urandom_range(0, 855) - 300,
                         $urandom_range(0, 255));
                else
                    vote($urandom_range(0, 32767) - 16384, $urandom_range(0, 32767) - 16384,
                         $urandom_range(0, 255));
            end
        end

        settle();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
